// ===== src/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types and constants for the SysTick-style down counter.
// ----------------------------------------------------------------------------
package sdc_pkg;

  localparam int unsigned KindWidth       = 2;
  localparam int unsigned SelWidth        = 2;
  localparam int unsigned DataWidth       = 32;
  localparam int unsigned CountWidthDflt  = 24;

  // control register bit positions
  localparam int unsigned CtrlRunBit  = 0;
  localparam int unsigned CtrlIntBit  = 1;
  localparam int unsigned CtrlClkBit  = 2;
  localparam int unsigned CtrlFlagBit = 16;

  typedef enum logic [KindWidth-1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  typedef enum logic [SelWidth-1:0] {
    SEL_CTRL    = 2'd0,
    SEL_RELOAD  = 2'd1,
    SEL_CURRENT = 2'd2
  } sel_e;

  typedef struct packed {
    logic [KindWidth-1:0] kind;
    logic [SelWidth-1:0]  reg_select;
    logic [DataWidth-1:0] write_value;
    logic                 ref_enable;
  } in_item_t;

  typedef struct packed {
    logic [DataWidth-1:0] read_value;
    logic                 irq;
  } out_item_t;

endpackage

// ===== src/sdc_in_if.sv =====
// ----------------------------------------------------------------------------
// sdc_in_if
// Valid/ready channel carrying one tick or register access transaction.
// ----------------------------------------------------------------------------
interface sdc_in_if
  import sdc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [KindWidth-1:0] kind;
  logic [SelWidth-1:0]  reg_select;
  logic [DataWidth-1:0] write_value;
  logic                 ref_enable;

  modport source (output valid, output kind, output reg_select, output write_value,
                  output ref_enable, input ready);
  modport sink   (input valid, input kind, input reg_select, input write_value,
                  input ref_enable, output ready);
endinterface

// ===== src/sdc_out_if.sv =====
// ----------------------------------------------------------------------------
// sdc_out_if
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface sdc_out_if
  import sdc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [DataWidth-1:0] read_value;
  logic                 irq;

  modport source (output valid, output read_value, output irq, input ready);
  modport sink   (input valid, input read_value, input irq, output ready);
endinterface

// ===== src/systick_down_counter.sv =====
// ----------------------------------------------------------------------------
// systick_down_counter
// SysTick-style down counter driven by tick and register access transactions.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle and returns exactly one result per
// transaction. The input register holds the transaction until it advances;
// then the timer state updates and the result lands in the output register,
// from which it can be taken. The output register frees up whenever its
// result is taken, so input stalls only while a result waits.
// Write single_shot only while the block is idle.
module systick_down_counter
  import sdc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDflt
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_data_i,
  sdc_in_if.sink   in_i,
  sdc_out_if.source out_o
);

  logic      stage_valid;
  in_item_t  stage_item;
  logic      adv;
  out_item_t result;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  assign adv = stage_valid && (!out_valid_q || out_o.ready);

  sdc_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  sdc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (adv),
    .item_i     (stage_item),
    .result_o   (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = out_item_q.read_value;
  assign out_o.irq        = out_item_q.irq;

endmodule

// ===== src/sdc_in_stage.sv =====
// ----------------------------------------------------------------------------
// sdc_in_stage
// Input register: captures a transaction, holds it until the core consumes it.
// ----------------------------------------------------------------------------
module sdc_in_stage
  import sdc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  sdc_in_if.sink   in_i,
  input  logic     adv_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_i.ready = !valid_q || adv_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.kind        <= in_i.kind;
      item_q.reg_select  <= in_i.reg_select;
      item_q.write_value <= in_i.write_value;
      item_q.ref_enable  <= in_i.ref_enable;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== src/sdc_core.sv =====
// ----------------------------------------------------------------------------
// sdc_core
// Timer state registers and the per-transaction update and read logic.
// ----------------------------------------------------------------------------
module sdc_core
  import sdc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDflt
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  logic                   single_shot_q;
  logic                   run_q, run_d;
  logic                   int_q, int_d;
  logic                   clk_sel_q, clk_sel_d;
  logic                   flag_q, flag_d;
  logic [COUNT_WIDTH-1:0] reload_q, reload_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   fire;

  assign fire = run_q && (clk_sel_q || item_i.ref_enable);

  always_comb begin
    run_d     = run_q;
    int_d     = int_q;
    clk_sel_d = clk_sel_q;
    flag_d    = flag_q;
    reload_d  = reload_q;
    count_d   = count_q;
    result_o  = '0;
    case (item_i.kind)
      KIND_TICK: begin
        if (fire) begin
          if (count_q == '0) begin
            count_d = reload_q;
          end else begin
            count_d = count_q - COUNT_WIDTH'(1);
            if (count_q == COUNT_WIDTH'(1)) begin
              flag_d       = 1'b1;
              result_o.irq = int_q;
              if (single_shot_q) begin
                run_d   = 1'b0;
                int_d   = 1'b0;
                count_d = '0;
              end
            end
          end
        end
      end
      KIND_READ: begin
        case (item_i.reg_select)
          SEL_CTRL: begin
            result_o.read_value[CtrlRunBit]  = run_q;
            result_o.read_value[CtrlIntBit]  = int_q;
            result_o.read_value[CtrlClkBit]  = clk_sel_q;
            result_o.read_value[CtrlFlagBit] = flag_q;
            flag_d = 1'b0;
          end
          SEL_RELOAD:  result_o.read_value = DataWidth'(reload_q);
          SEL_CURRENT: result_o.read_value = DataWidth'(count_q);
          default: ;
        endcase
      end
      KIND_WRITE: begin
        case (item_i.reg_select)
          SEL_CTRL: begin
            run_d     = item_i.write_value[CtrlRunBit];
            int_d     = item_i.write_value[CtrlIntBit];
            clk_sel_d = item_i.write_value[CtrlClkBit];
          end
          SEL_RELOAD: reload_d = item_i.write_value[COUNT_WIDTH-1:0];
          SEL_CURRENT: begin
            count_d = '0;
            flag_d  = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_shot_q <= 1'b0;
      run_q         <= 1'b0;
      int_q         <= 1'b0;
      clk_sel_q     <= 1'b0;
      flag_q        <= 1'b0;
      reload_q      <= '0;
      count_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        single_shot_q <= cfg_data_i;
      end
      if (step_i) begin
        run_q     <= run_d;
        int_q     <= int_d;
        clk_sel_q <= clk_sel_d;
        flag_q    <= flag_d;
        reload_q  <= reload_d;
        count_q   <= count_d;
      end
    end
  end

endmodule

// ===== tb/tb_systick_down_counter.sv =====
// ----------------------------------------------------------------------------
// tb_systick_down_counter
// Self-checking bench for the SysTick-style down counter: a directed table of
// register accesses and ticks, then random traffic in periodic and single-shot
// mode under several sender/receiver idle patterns. Each result is checked
// against a known table value or a timer predictor in step with acceptances.
// ----------------------------------------------------------------------------
module tb_systick_down_counter;
  import sdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CountW      = CountWidthDflt;
  localparam logic [KindWidth-1:0] KindNone  = 2'd3;
  localparam logic [SelWidth-1:0]  SelUnused = 2'd3;
  localparam int unsigned ItemsPerPhase = 375;
  localparam int unsigned NumPhases     = 4;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned SettleCycles  = 4;

  localparam int unsigned GapPct[NumPhases]   = '{0, 71, 0, 25};
  localparam int unsigned StallPct[NumPhases] = '{0, 0, 71, 25};

  typedef struct packed {
    in_item_t  stim;
    logic      known_ok;
    out_item_t known;
  } access_row_t;

  localparam int unsigned NumRows = 28;
  localparam access_row_t DIRECTED[NumRows] = '{
    '{'{KIND_READ,  SEL_CTRL,    32'h0000_0000, 1'b0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_READ,  SEL_RELOAD,  32'h0000_0000, 1'b0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_READ,  SEL_CURRENT, 32'h0000_0000, 1'b0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_READ,  SelUnused,   32'hFFFF_FFFF, 1'b1}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KindNone,   SelUnused,   32'hFFFF_FFFF, 1'b1}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_WRITE, SEL_RELOAD,  32'hFFFF_FFFF, 1'b0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_READ,  SEL_RELOAD,  32'h0000_0000, 1'b0}, 1'b1, '{32'h00FF_FFFF, 1'b0}},
    '{'{KIND_WRITE, SEL_CTRL,    32'hFFFF_FFF8, 1'b1}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_READ,  SEL_CTRL,    32'h0000_0000, 1'b0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_WRITE, SEL_CTRL,    32'h0000_0007, 1'b0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_TICK,  SEL_CTRL,    32'hFFFF_FFFF, 1'b0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_READ,  SEL_CURRENT, 32'h0000_0000, 1'b0}, 1'b1, '{32'h00FF_FFFF, 1'b0}},
    '{'{KIND_WRITE, SEL_RELOAD,  32'h0000_0002, 1'b0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_WRITE, SEL_CURRENT, 32'hFFFF_FFFF, 1'b1}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_TICK,  SEL_RELOAD,  32'h0000_0000, 1'b0}, 1'b0, '{32'h0000_0000, 1'b0}},
    '{'{KIND_TICK,  SEL_CURRENT, 32'h1234_5678, 1'b1}, 1'b0, '{32'h0000_0000, 1'b0}},
    '{'{KIND_TICK,  SEL_CTRL,    32'h0000_0000, 1'b0}, 1'b1, '{32'h0000_0000, 1'b1}},
    '{'{KIND_READ,  SEL_CTRL,    32'h0000_0000, 1'b0}, 1'b1, '{32'h0001_0007, 1'b0}},
    '{'{KIND_READ,  SEL_CTRL,    32'h0000_0000, 1'b0}, 1'b1, '{32'h0000_0007, 1'b0}},
    '{'{KIND_WRITE, SEL_CTRL,    32'h0000_0001, 1'b0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_TICK,  SEL_CTRL,    32'h0000_0000, 1'b0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_TICK,  SEL_CTRL,    32'h0000_0000, 1'b1}, 1'b0, '{32'h0000_0000, 1'b0}},
    '{'{KIND_WRITE, SelUnused,   32'hFFFF_FFFF, 1'b1}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_READ,  SEL_RELOAD,  32'h0000_0000, 1'b0}, 1'b1, '{32'h0000_0002, 1'b0}},
    '{'{KIND_WRITE, SEL_RELOAD,  32'h0000_0000, 1'b0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_WRITE, SEL_CURRENT, 32'h0000_0000, 1'b0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{KIND_TICK,  SEL_CTRL,    32'h0000_0000, 1'b1}, 1'b0, '{32'h0000_0000, 1'b0}},
    '{'{KIND_READ,  SEL_CURRENT, 32'h0000_0000, 1'b0}, 1'b1, '{32'h0000_0000, 1'b0}}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_data_i;

  sdc_in_if  in_ch ();
  sdc_out_if out_ch ();

  systick_down_counter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // timer predictor state
  logic              tmr_single_shot;
  logic              tmr_run;
  logic              tmr_int_en;
  logic              tmr_core_clk;
  logic              tmr_flag;
  logic [CountW-1:0] tmr_reload;
  logic [CountW-1:0] tmr_count;

  out_item_t   expected_results[$];
  int unsigned mismatches;
  int unsigned send_gap_pct;
  int unsigned stall_pct;
  int unsigned idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_item_t predict_access(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.kind)
      KIND_TICK: begin
        if (tmr_run && (tmr_core_clk || it.ref_enable)) begin
          if (tmr_count == '0) begin
            tmr_count = tmr_reload;
          end else begin
            tmr_count = tmr_count - CountW'(1);
            if (tmr_count == '0) begin
              tmr_flag = 1'b1;
              r.irq    = tmr_int_en;
              if (tmr_single_shot) begin
                tmr_run    = 1'b0;
                tmr_int_en = 1'b0;
              end
            end
          end
        end
      end
      KIND_READ: begin
        case (it.reg_select)
          SEL_CTRL: begin
            r.read_value[CtrlRunBit]  = tmr_run;
            r.read_value[CtrlIntBit]  = tmr_int_en;
            r.read_value[CtrlClkBit]  = tmr_core_clk;
            r.read_value[CtrlFlagBit] = tmr_flag;
            tmr_flag = 1'b0;
          end
          SEL_RELOAD:  r.read_value = DataWidth'(tmr_reload);
          SEL_CURRENT: r.read_value = DataWidth'(tmr_count);
          default: ;
        endcase
      end
      KIND_WRITE: begin
        case (it.reg_select)
          SEL_CTRL: begin
            tmr_run      = it.write_value[CtrlRunBit];
            tmr_int_en   = it.write_value[CtrlIntBit];
            tmr_core_clk = it.write_value[CtrlClkBit];
          end
          SEL_RELOAD: tmr_reload = it.write_value[CountW-1:0];
          SEL_CURRENT: begin
            tmr_count = '0;
            tmr_flag  = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t random_access();
    in_item_t    it;
    int unsigned pick;
    it.write_value = $urandom();
    it.ref_enable  = 1'($urandom_range(1));
    it.reg_select  = SelWidth'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 55) begin
      it.kind = KIND_TICK;
    end else if (pick < 70) begin
      it.kind = KIND_READ;
    end else if (pick < 95) begin
      it.kind = KIND_WRITE;
      pick = $urandom_range(99);
      if (pick < 40) begin
        it.reg_select = SEL_CTRL;
        if ($urandom_range(9) < 8) it.write_value[CtrlRunBit] = 1'b1;
      end else if (pick < 70) begin
        it.reg_select = SEL_RELOAD;
        // short periods so expiries come often; upper bits stay random
        if ($urandom_range(9) < 8) it.write_value[CountW-1:0] = CountW'($urandom_range(12));
      end else if (pick < 95) begin
        it.reg_select = SEL_CURRENT;
      end else begin
        it.reg_select = SelUnused;
      end
    end else begin
      it.kind = KindNone;
    end
    return it;
  endfunction

  task automatic push_access(input in_item_t it, input logic known_ok, input out_item_t known);
    out_item_t pred;
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= it.kind;
    in_ch.reg_select  <= it.reg_select;
    in_ch.write_value <= it.write_value;
    in_ch.ref_enable  <= it.ref_enable;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pred = predict_access(it);
    expected_results.push_back(known_ok ? known : pred);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_single_shot(input logic value);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tmr_single_shot = value;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    out_item_t exp;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with none expected: read_value %h irq %b",
               out_ch.read_value, out_ch.irq);
        mismatches++;
      end else begin
        exp = expected_results.pop_front();
        if (out_ch.read_value !== exp.read_value) begin
          $error("read_value expected %h actual %h", exp.read_value, out_ch.read_value);
          mismatches++;
        end
        if (out_ch.irq !== exp.irq) begin
          $error("irq expected %b actual %b", exp.irq, out_ch.irq);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_item_t it;
    send_gap_pct    = 0;
    stall_pct       = 0;
    tmr_single_shot = 1'b0;
    tmr_run         = 1'b0;
    tmr_int_en      = 1'b0;
    tmr_core_clk    = 1'b0;
    tmr_flag        = 1'b0;
    tmr_reload      = '0;
    tmr_count       = '0;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_data_i        <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_TICK;
    in_ch.reg_select  <= SEL_CTRL;
    in_ch.write_value <= '0;
    in_ch.ref_enable  <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_single_shot(1'b0);
    for (int unsigned i = 0; i < NumRows; i++) begin
      push_access(DIRECTED[i].stim, DIRECTED[i].known_ok, DIRECTED[i].known);
    end

    for (int unsigned p = 0; p < NumPhases; p++) begin
      write_single_shot((p % 2) == 0);
      send_gap_pct = GapPct[p];
      stall_pct    = StallPct[p];
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        if (n == ItemsPerPhase / 2) wait_drained();
        it = random_access();
        push_access(it, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sdc_pkg.sv
src/sdc_in_if.sv
src/sdc_out_if.sv
src/sdc_in_stage.sv
src/sdc_core.sv
src/systick_down_counter.sv
tb/tb_systick_down_counter.sv
